// ===== rtl/efw_pkg.sv =====
// Shared types, constants and the exponential lookup table of the fuzz waveshaper.
package efw_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 12;
    localparam int MIX_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int AX_W      = SAMPLE_W + 1;
    // g*|x| is at most 2560 * 2^15 < 2^27
    localparam int T_W       = 27;
    localparam int IDX_W     = 8;
    localparam int FRAC_W    = 8;
    localparam int IDX_LSB   = SAMPLE_W + 3;
    localparam int FRAC_LSB  = SAMPLE_W - 5;
    localparam int EXP_W     = 16;
    localparam int EXP_ENTRIES = 257;
    localparam int ROM_A_W   = 9;

    localparam logic [GAIN_W-1:0] GAIN_MIN   = GAIN_W'(256);
    localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(2560);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(2560);
    localparam logic [MIX_W-1:0]  MIX_ONE    = MIX_W'(256);
    localparam logic [MIX_W-1:0]  MIX_RESET  = MIX_W'(128);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX    = 2'd1;

    // Sideband that travels with each sample down the pipeline
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [SAMPLE_W-1:0] x;
        logic [MIX_W-1:0]           mix;
    } t_side;

    typedef logic [EXP_W-1:0] t_exp_rom [0:EXP_ENTRIES-1];

    // (a*b) >> 62 built from 32-bit halves
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl, hh, hl, lh, ll, mid, hi;
        ah  = a >> 32;
        al  = a & 64'hFFFF_FFFF;
        bh  = b >> 32;
        bl  = b & 64'hFFFF_FFFF;
        hh  = ah * bh;
        hl  = ah * bl;
        lh  = al * bh;
        ll  = al * bl;
        mid = (ll >> 32) + (hl & 64'hFFFF_FFFF) + (lh & 64'hFFFF_FFFF);
        hi  = hh + (hl >> 32) + (lh >> 32) + (mid >> 32);
        return (hi << 2) | ((mid >> 30) & 64'd3);
    endfunction

    // Table of round(65535*exp(-k/16)), evaluated at elaboration only
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] sum, term, p, q;
        int          n, k;
        sum  = 64'd1 << 62;
        term = sum;
        p    = sum;
        for (n = 1; n <= 24; n++) begin
            term = term / 64'(16 * n);
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (k = 0; k < EXP_ENTRIES; k++) begin
            q      = p >> 20;
            rom[k] = EXP_W'((q * 64'd65535 + (64'd1 << 41)) >> 42);
            p      = mul_q62(p, sum);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

// ===== rtl/efw_exp.sv =====
// Shaping path: gain multiply, exp table lookup with interpolation, 1 - exp.
module efw_exp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  efw_pkg::t_side               i_side,
    input  logic [efw_pkg::AX_W-1:0]     i_ax,
    input  logic [efw_pkg::GAIN_W-1:0]   i_gain,
    output efw_pkg::t_side               o_side,
    output logic [efw_pkg::EXP_W-1:0]    o_ym
);

    efw_pkg::t_side                    r_side_a, r_side_b, r_side_c;
    logic [efw_pkg::T_W-1:0]           r_t;
    logic [efw_pkg::EXP_W-1:0]         r_a, r_d, r_ym;
    logic [efw_pkg::FRAC_W-1:0]        r_f;

    logic [efw_pkg::IDX_W-1:0]         idx;
    logic [efw_pkg::ROM_A_W-1:0]       addr_lo, addr_hi;
    logic [efw_pkg::EXP_W-1:0]         tab_lo, tab_hi;
    logic [efw_pkg::EXP_W+efw_pkg::FRAC_W-1:0] interp;
    logic [efw_pkg::EXP_W-1:0]         n_e;

    // Table index and fraction; the clamped gain keeps the index below the last entry
    assign idx     = r_t[efw_pkg::IDX_LSB +: efw_pkg::IDX_W];
    assign addr_lo = {1'b0, idx};
    assign addr_hi = addr_lo + efw_pkg::ROM_A_W'(1);
    assign tab_lo  = efw_pkg::EXP_ROM[addr_lo];
    assign tab_hi  = efw_pkg::EXP_ROM[addr_hi];

    // Interpolate toward the smaller (next) entry, truncating
    assign interp  = r_d * r_f;
    assign n_e     = r_a - interp[efw_pkg::FRAC_W +: efw_pkg::EXP_W];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_a.valid <= 1'b0;
            r_side_b.valid <= 1'b0;
            r_side_c.valid <= 1'b0;
        end else begin
            r_side_a.valid <= i_side.valid;
            r_side_b.valid <= r_side_a.valid;
            r_side_c.valid <= r_side_b.valid;
        end
    end

    // Payload stages: t = g*|x|, table read, interpolation
    always_ff @(posedge i_clk) begin
        r_side_a.last <= i_side.last;
        r_side_a.x    <= i_side.x;
        r_side_a.mix  <= i_side.mix;
        r_t           <= efw_pkg::T_W'(i_gain * i_ax);

        r_side_b.last <= r_side_a.last;
        r_side_b.x    <= r_side_a.x;
        r_side_b.mix  <= r_side_a.mix;
        r_a           <= tab_lo;
        r_d           <= tab_lo - tab_hi;
        r_f           <= r_t[efw_pkg::FRAC_LSB +: efw_pkg::FRAC_W];

        r_side_c.last <= r_side_b.last;
        r_side_c.x    <= r_side_b.x;
        r_side_c.mix  <= r_side_b.mix;
        r_ym          <= ~n_e;
    end

    assign o_side = r_side_c;
    assign o_ym   = r_ym;

endmodule

// ===== rtl/efw_mix.sv =====
// Dry/wet blend, rounding and saturation to the output sample.
module efw_mix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  efw_pkg::t_side                i_side,
    input  logic [efw_pkg::EXP_W-1:0]     i_ym,
    output logic                          o_strobe,
    output logic signed [efw_pkg::SAMPLE_W-1:0] o_sample,
    output logic                          o_last
);

    localparam int PW_W = efw_pkg::EXP_W + 1 + efw_pkg::MIX_W + 1;
    localparam int PD_W = efw_pkg::SAMPLE_W + efw_pkg::MIX_W;
    localparam int S_W  = PW_W + 1;
    localparam int R_W  = S_W - efw_pkg::MIX_W;

    logic signed [efw_pkg::EXP_W:0]       ys;
    logic [efw_pkg::MIX_W-1:0]            dry;
    logic signed [PW_W-1:0]               n_pw, r_pw;
    logic signed [PD_W-1:0]               n_pd, r_pd;
    logic                                 r_valid_d, r_last_d;
    logic signed [S_W-1:0]                s;
    logic signed [R_W-1:0]                rnd;
    logic signed [efw_pkg::SAMPLE_W-1:0]  n_sample, r_sample;
    logic                                 r_strobe, r_last;

    // Signed shaped value and both mix products
    assign ys   = i_side.x[efw_pkg::SAMPLE_W-1] ? -$signed({1'b0, i_ym})
                                                : $signed({1'b0, i_ym});
    assign dry  = efw_pkg::MIX_ONE - i_side.mix;
    assign n_pw = ys * $signed({1'b0, i_side.mix});
    assign n_pd = i_side.x * $signed({1'b0, dry});

    // Sum, add half an LSB, floor, then clip to the sample range
    assign s   = S_W'(r_pw) + (S_W'(r_pd) <<< 1) + S_W'(256);
    assign rnd = s[S_W-1:efw_pkg::MIX_W];

    always_comb begin
        if (rnd > R_W'(signed'(32767))) begin
            n_sample = 16'sh7FFF;
        end else if (rnd < -R_W'(signed'(32768))) begin
            n_sample = 16'sh8000;
        end else begin
            n_sample = rnd[efw_pkg::SAMPLE_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_d <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_valid_d <= i_side.valid;
            r_strobe  <= r_valid_d;
        end
    end

    // Hold products, then the finished sample
    always_ff @(posedge i_clk) begin
        r_pw     <= n_pw;
        r_pd     <= n_pd;
        r_last_d <= i_side.last;
        r_sample <= n_sample;
        r_last   <= r_last_d;
    end

    assign o_strobe = r_strobe;
    assign o_sample = r_sample;
    assign o_last   = r_last;

endmodule

// ===== rtl/exponential_fuzz_waveshaper.sv =====
// Top level of the exponential soft-clip fuzz waveshaper with dry/wet mix.
// One Q1.15 sample is taken per clock on every cycle with start high, and its
// result appears on o_sample_out with o_strobe high for one cycle, after
// passing six register stages (input, gain multiply, table read,
// interpolation, mix multiply, round and clip). busy stays low, and
// the receiver must take every transfer in the cycle it is shown. Gain and mix
// are written through the configuration port and take effect for samples that
// enter after the write; change them only while no sample is in flight.
module exponential_fuzz_waveshaper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [efw_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                 i_block_last_in,
    output logic                                 o_strobe,
    output logic signed [efw_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                 o_block_last_out,
    input  logic                                 i_cfg_we,
    input  logic [efw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [efw_pkg::GAIN_W-1:0]           i_cfg_data
);

    logic [efw_pkg::GAIN_W-1:0]           r_drive_gain, gain_clamp, r_gain;
    logic [efw_pkg::MIX_W-1:0]            r_wet_mix, mix_clamp;
    logic signed [efw_pkg::SAMPLE_W:0]    x_ext;
    logic [efw_pkg::AX_W-1:0]             n_ax, r_ax;
    efw_pkg::t_side                       r_side_1, exp_side;
    logic [efw_pkg::EXP_W-1:0]            exp_ym;

    assign busy = 1'b0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_gain <= efw_pkg::GAIN_RESET;
            r_wet_mix    <= efw_pkg::MIX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                efw_pkg::CFG_DRIVE_GAIN: r_drive_gain <= i_cfg_data;
                efw_pkg::CFG_WET_MIX:    r_wet_mix    <= i_cfg_data[efw_pkg::MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp gain to 1..10 and mix to at most 1
    always_comb begin
        if (r_drive_gain < efw_pkg::GAIN_MIN) begin
            gain_clamp = efw_pkg::GAIN_MIN;
        end else if (r_drive_gain > efw_pkg::GAIN_MAX) begin
            gain_clamp = efw_pkg::GAIN_MAX;
        end else begin
            gain_clamp = r_drive_gain;
        end
        if (r_wet_mix > efw_pkg::MIX_ONE) begin
            mix_clamp = efw_pkg::MIX_ONE;
        end else begin
            mix_clamp = r_wet_mix;
        end
    end

    // Magnitude of the sample; the most negative code gives exactly 1.0
    assign x_ext = {i_sample_in[efw_pkg::SAMPLE_W-1], i_sample_in};
    assign n_ax  = i_sample_in[efw_pkg::SAMPLE_W-1] ? efw_pkg::AX_W'(-x_ext)
                                                    : efw_pkg::AX_W'(x_ext);

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_1.valid <= 1'b0;
        end else begin
            r_side_1.valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_1.last <= i_block_last_in;
        r_side_1.x    <= i_sample_in;
        r_side_1.mix  <= mix_clamp;
        r_ax          <= n_ax;
        r_gain        <= gain_clamp;
    end

    efw_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_side_1),
        .i_ax    (r_ax),
        .i_gain  (r_gain),
        .o_side  (exp_side),
        .o_ym    (exp_ym)
    );

    efw_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_side   (exp_side),
        .i_ym     (exp_ym),
        .o_strobe (o_strobe),
        .o_sample (o_sample_out),
        .o_last   (o_block_last_out)
    );

endmodule

// ===== rtl/efw_checker.sv =====
// Port-level checks of the waveshaper pipeline, bound to the top level.
module efw_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [efw_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                 i_block_last_in,
    input  logic                                 o_strobe,
    input  logic signed [efw_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  logic                                 o_block_last_out
);

    // Every accepted sample comes out with o_strobe high
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("accepted sample produced no result");

    // No result without a matching earlier transfer
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 6))
        else $error("result without matching input");

    // Block marker follows its sample
    a_last_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_block_last_out == $past(i_block_last_in, 6)))
        else $error("block marker out of step");

    // Silence stays silent
    a_zero_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_sample_in, 6) == '0)) |-> (o_sample_out == '0))
        else $error("zero input gave nonzero output");

endmodule

bind exponential_fuzz_waveshaper efw_checker u_efw_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the exponential fuzz waveshaper: corners, then random streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int DRAIN_WAIT    = 100;
    localparam int RAND_SEGMENTS = 8;
    localparam int SEG_ITEMS     = 175;

    // Clamp bounds of gain (Q4.8) and mix (Q1.8)
    localparam int DRIVE_LO = 256;
    localparam int DRIVE_HI = 2560;
    localparam int MIX_FULL = 256;

    // Register indexes the block does not decode
    localparam logic [efw_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [efw_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [efw_pkg::SAMPLE_W-1:0] sample;
        logic                                last;
    } t_shaped;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic signed [efw_pkg::SAMPLE_W-1:0] i_sample_in = '0;
    logic                                i_block_last_in = 1'b0;
    logic                                o_strobe;
    logic signed [efw_pkg::SAMPLE_W-1:0] o_sample_out;
    logic                                o_block_last_out;
    logic                                i_cfg_we = 1'b0;
    logic [efw_pkg::CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [efw_pkg::GAIN_W-1:0]          i_cfg_data = '0;

    // Mirror of the block's registers and the exp(-k/16) table
    logic [efw_pkg::GAIN_W-1:0] gain_reg;
    logic [efw_pkg::MIX_W-1:0]  mix_reg;
    int                         exp_tab [0:256];

    t_shaped shaped_q [$];
    t_shaped want_res;
    int      idle_pct;
    int      errors;
    int      sent;
    int      directed;
    int      results_seen;
    int      reg_writes;
    int      cycles;

    exponential_fuzz_waveshaper u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sample_in      (i_sample_in),
        .i_block_last_in  (i_block_last_in),
        .o_strobe         (o_strobe),
        .o_sample_out     (o_sample_out),
        .o_block_last_out (o_block_last_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Soft clip, then dry/wet mix, rounded half up and saturated to Q1.15
    function automatic t_shaped shape_sample(input logic signed [efw_pkg::SAMPLE_W-1:0] x,
                                             input logic last);
        t_shaped res;
        int      xi, axi, gi, mi, ti, idx, frac, ea, eb, e, ym, ys;
        longint  acc, r;
        xi  = x;
        axi = (xi < 0) ? -xi : xi;
        gi  = gain_reg;
        if (gi < DRIVE_LO) gi = DRIVE_LO;
        if (gi > DRIVE_HI) gi = DRIVE_HI;
        mi  = mix_reg;
        if (mi > MIX_FULL) mi = MIX_FULL;
        ti  = gi * axi;
        idx = ti >> 19;
        if (idx >= 256) begin
            e = exp_tab[256];
        end else begin
            frac = (ti >> 11) & 255;
            ea   = exp_tab[idx];
            eb   = exp_tab[idx + 1];
            e    = ea - (((ea - eb) * frac) >> 8);
        end
        ym  = 65535 - e;
        ys  = (xi < 0) ? -ym : ym;
        acc = longint'(ys) * mi * 32768 + longint'(xi) * (MIX_FULL - mi) * 65536;
        r   = (acc + 64'sd8388608) >>> 24;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        res.sample = r[efw_pkg::SAMPLE_W-1:0];
        res.last   = last;
        return res;
    endfunction

    // Small magnitudes where the curve bends, plus full range and near full scale
    function automatic logic signed [efw_pkg::SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(7))
            0, 1: v = $urandom_range(65535) - 32768;
            2, 3: v = $urandom_range(600);
            4:    v = 32767 - $urandom_range(63);
            default: v = $urandom_range(32767);
        endcase
        if ($urandom_range(1) == 1) v = -v;
        if (v == -32767 && $urandom_range(3) == 0) v = -32768;
        return v[efw_pkg::SAMPLE_W-1:0];
    endfunction

    // Present one sample and hold it until the transfer
    task automatic send_sample(input logic signed [efw_pkg::SAMPLE_W-1:0] s, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_sample_in     <= s;
        i_block_last_in <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        shaped_q.push_back(shape_sample(s, last));
        sent++;
    endtask

    // Stop sending and wait until every expected result is back
    task automatic drain();
        int waited;
        start <= 1'b0;
        waited = 0;
        while (shaped_q.size() != 0 && waited < DRAIN_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; only called with nothing in flight
    task automatic write_reg(input logic [efw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [efw_pkg::GAIN_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == efw_pkg::CFG_DRIVE_GAIN) begin
            gain_reg = data;
        end else if (idx == efw_pkg::CFG_WET_MIX) begin
            mix_reg = data[efw_pkg::MIX_W-1:0];
        end
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Reset values: gain 10.0, mix 0.5
    task automatic test_defaults();
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd16384, 1'b1);
        send_sample(-16'sd16384, 1'b0);
        drain();
    endtask

    // Gain and mix at both ends of their ranges and beyond them
    task automatic test_register_extremes();
        logic [efw_pkg::GAIN_W-1:0] gains [5];
        logic [efw_pkg::GAIN_W-1:0] mixes [5];
        gains = '{12'd256, 12'd2560, 12'd0, 12'd4095, 12'd1000};
        mixes = '{12'd256, 12'd0, 12'd511, 12'd4095, 12'd200};
        for (int i = 0; i < 5; i++) begin
            write_reg(efw_pkg::CFG_DRIVE_GAIN, gains[i]);
            write_reg(efw_pkg::CFG_WET_MIX, mixes[i]);
            send_sample(16'sd32767, 1'b1);
            send_sample(-16'sd32768, 1'b0);
            send_sample(16'sd5, 1'b1);
            drain();
        end
    endtask

    // Writes to undecoded indexes must leave gain and mix alone
    task automatic test_unknown_index();
        write_reg(CFG_SPARE_A, efw_pkg::GAIN_W'($urandom_range(4095)));
        write_reg(CFG_SPARE_B, efw_pkg::GAIN_W'($urandom_range(4095)));
        send_sample(16'sd300, 1'b0);
        send_sample(-16'sd9000, 1'b1);
        drain();
    endtask

    // Random streams under changing settings and three sender idle profiles
    task automatic test_random_segments();
        for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
            if (seg < 3) begin
                idle_pct = 27;
            end else if (seg < 6) begin
                idle_pct = 76;
            end else begin
                idle_pct = 0;
            end
            if ($urandom_range(3) == 0) begin
                write_reg(efw_pkg::CFG_DRIVE_GAIN, efw_pkg::GAIN_W'($urandom_range(4095)));
            end else begin
                write_reg(efw_pkg::CFG_DRIVE_GAIN,
                          efw_pkg::GAIN_W'($urandom_range(DRIVE_HI, DRIVE_LO)));
            end
            if ($urandom_range(3) == 0) begin
                write_reg(efw_pkg::CFG_WET_MIX, efw_pkg::GAIN_W'($urandom_range(4095)));
            end else begin
                write_reg(efw_pkg::CFG_WET_MIX, efw_pkg::GAIN_W'($urandom_range(MIX_FULL)));
            end
            for (int n = 0; n < SEG_ITEMS; n++) begin
                send_sample(pick_sample(), $urandom_range(7) == 0);
            end
            drain();
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (shaped_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: sample_out=%0d block_last_out=%0b",
                         $time, o_sample_out, o_block_last_out);
            end else begin
                want_res = shaped_q.pop_front();
                results_seen++;
                if (o_sample_out !== want_res.sample) begin
                    errors++;
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, want_res.sample, o_sample_out);
                end
                if (o_block_last_out !== want_res.last) begin
                    errors++;
                    $display("%0t: block_last_out expected %0b actual %0b",
                             $time, want_res.last, o_block_last_out);
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("FAIL exponential_fuzz_waveshaper");
            $finish;
        end
    end

    initial begin
        errors       = 0;
        sent         = 0;
        results_seen = 0;
        reg_writes   = 0;
        cycles       = 0;
        idle_pct     = 0;
        gain_reg     = 12'd2560;
        mix_reg      = 9'd128;
        for (int k = 0; k <= 256; k++) begin
            exp_tab[k] = int'($floor(65535.0 * $exp(-k / 16.0) + 0.5));
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_register_extremes();
        test_unknown_index();
        directed = sent;
        test_random_segments();

        if (shaped_q.size() != 0) begin
            errors += shaped_q.size();
            $display("%0t: %0d expected results never arrived", $time, shaped_q.size());
        end
        $display("Run covered %0d samples (%0d directed) and %0d results",
                 sent, directed, results_seen);
        $display("over %0d register writes, with gain and mix swept to and past both ends",
                 reg_writes);
        $display("under three sender idle rates.");
        if (errors == 0) begin
            $display("PASS exponential_fuzz_waveshaper");
        end else begin
            $display("FAIL exponential_fuzz_waveshaper");
        end
        $finish;
    end

endmodule
